@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// clocked property, also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/mcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpg_pkg
// types and constants shared by the midpoint circle pixel generator
// ----------------------------------------------------------------------------
`default_nettype none

package mcpg_pkg;

  localparam int COORD_BITS = 10;
  localparam int MAX_RADIUS = 10;
  localparam int RAD_BITS   = 4;
  localparam int PIX_BITS   = 12;
  localparam int STEP_BITS  = RAD_BITS + 1;
  localparam int DEC_BITS   = 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;

  localparam logic signed [PIX_BITS-1:0] PIX_MIN = -PIX_BITS'(MAX_RADIUS);
  localparam logic signed [PIX_BITS-1:0] PIX_MAX =
    PIX_BITS'((2 ** COORD_BITS) - 1 + MAX_RADIUS);

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [RAD_BITS-1:0]   circle_radius;
  } cmd_t;

  typedef struct packed {
    logic signed [PIX_BITS-1:0] pixel_x;
    logic signed [PIX_BITS-1:0] pixel_y;
    logic                       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [RAD_BITS-1:0]   radius;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    OCT_XP_YP = 3'd0,
    OCT_XP_YM = 3'd1,
    OCT_XM_YM = 3'd2,
    OCT_XM_YP = 3'd3,
    OCT_YP_XP = 3'd4,
    OCT_YP_XM = 3'd5,
    OCT_YM_XM = 3'd6,
    OCT_YM_XP = 3'd7
  } oct_t;

endpackage

`default_nettype wire

@@ hw/rtl/mcpg_front.sv @@
// ----------------------------------------------------------------------------
// mcpg_front
// takes circle commands, saturates the radius and pushes them to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module mcpg_front (
  input  wire              cmd_valid,
  output logic             cmd_stall,
  input  mcpg_pkg::cmd_t   cmd,
  input  mcpg_pkg::q_stat_t q_stat,
  output logic             push,
  output mcpg_pkg::job_t   push_job
);
  import mcpg_pkg::*;

  always_comb begin
    cmd_stall       = q_stat.full;
    push            = cmd_valid && !q_stat.full;
    push_job.cx     = cmd.center_x;
    push_job.cy     = cmd.center_y;
    if (cmd.circle_radius > RAD_BITS'(MAX_RADIUS)) begin
      push_job.radius = RAD_BITS'(MAX_RADIUS);
    end else begin
      push_job.radius = cmd.circle_radius;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mcpg_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// mcpg_cmd_queue
// short register queue between the command front and the pixel engine
// ----------------------------------------------------------------------------
`default_nettype none

module mcpg_cmd_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  mcpg_pkg::job_t    push_job,
  input  wire               pop,
  output mcpg_pkg::job_t    pop_job,
  output mcpg_pkg::q_stat_t q_stat
);
  import mcpg_pkg::*;

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  logic do_push;
  logic do_pop;

  always_comb begin
    q_stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
    q_stat.empty = (count == '0);
    do_push      = push && !q_stat.full;
    do_pop       = pop && !q_stat.empty;
    pop_job      = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mcpg_back.sv @@
// ----------------------------------------------------------------------------
// mcpg_back
// midpoint circle engine: one pixel per cycle while the output is not stalled, into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module mcpg_back (
  input  wire               clk,
  input  wire               rst,
  input  mcpg_pkg::q_stat_t q_stat,
  input  mcpg_pkg::job_t    pop_job,
  output logic              pop,
  output logic              pix_valid,
  input  wire               pix_stall,
  output mcpg_pkg::pix_t    pix
);
  import mcpg_pkg::*;

  logic                        busy;
  logic [COORD_BITS-1:0]       held_cx;
  logic [COORD_BITS-1:0]       held_cy;
  logic signed [STEP_BITS-1:0] step_x;
  logic signed [STEP_BITS-1:0] step_y;
  logic signed [DEC_BITS-1:0]  decision_value;
  oct_t                        octant_index;

  logic                        advance;
  logic signed [PIX_BITS-1:0]  ecx, ecy, ex, ey;
  logic signed [PIX_BITS-1:0]  px, py;
  logic signed [STEP_BITS-1:0] x_next, y_next;
  logic signed [DEC_BITS-1:0]  d_next;
  logic signed [DEC_BITS-1:0]  dx, dy;
  logic                        last;

  always_comb begin
    advance = !pix_valid || !pix_stall;
    pop     = !busy && !q_stat.empty;
    ecx     = PIX_BITS'(held_cx);
    ecy     = PIX_BITS'(held_cy);
    ex      = PIX_BITS'(step_x);
    ey      = PIX_BITS'(step_y);
    dx      = DEC_BITS'(step_x);
    dy      = DEC_BITS'(step_y);

    unique case (octant_index)
      OCT_XP_YP: begin px = ecx + ex; py = ecy + ey; end
      OCT_XP_YM: begin px = ecx + ex; py = ecy - ey; end
      OCT_XM_YM: begin px = ecx - ex; py = ecy - ey; end
      OCT_XM_YP: begin px = ecx - ex; py = ecy + ey; end
      OCT_YP_XP: begin px = ecx + ey; py = ecy + ex; end
      OCT_YP_XM: begin px = ecx + ey; py = ecy - ex; end
      OCT_YM_XM: begin px = ecx - ey; py = ecy - ex; end
      OCT_YM_XP: begin px = ecx - ey; py = ecy + ex; end
      default:   begin px = ecx;      py = ecy;      end
    endcase

    x_next = step_x + STEP_BITS'(1);
    if (decision_value < 0) begin
      d_next = decision_value + (dx <<< 2) + DEC_BITS'(6);
      y_next = step_y;
    end else begin
      d_next = decision_value + ((dx - dy) <<< 2) + DEC_BITS'(10);
      y_next = step_y - STEP_BITS'(1);
    end
    last = (octant_index == OCT_YM_XP) && (x_next > y_next);
  end

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      pix.pixel_x    <= px;
      pix.pixel_y    <= py;
      pix.last_pixel <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      pix_valid      <= 1'b0;
      held_cx        <= '0;
      held_cy        <= '0;
      step_x         <= '0;
      step_y         <= '0;
      decision_value <= '0;
      octant_index   <= OCT_XP_YP;
    end else begin
      if (advance) begin
        pix_valid <= busy;
      end
      if (pop) begin
        busy           <= 1'b1;
        held_cx        <= pop_job.cx;
        held_cy        <= pop_job.cy;
        step_x         <= '0;
        step_y         <= STEP_BITS'(pop_job.radius);
        decision_value <= DEC_BITS'(3) - DEC_BITS'({pop_job.radius, 1'b0});
        octant_index   <= OCT_XP_YP;
      end else if (busy && advance) begin
        octant_index <= oct_t'(octant_index + 3'd1);
        if (octant_index == OCT_YM_XP) begin
          step_x         <= x_next;
          step_y         <= y_next;
          decision_value <= d_next;
          if (last) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/midpoint_circle_pixel_generator.sv @@
// a command accepted by the front goes through the queue and the engine state registers
// before its first pixel beat is registered; the engine gives 8 pixel beats per midpoint
//   step plus a load step per circle, one pixel per cycle while the output is not stalled
// a two-entry command queue lets the front accept while the engine draws
// reset: synchronous, clears the queue, the engine state and the output valid
// ----------------------------------------------------------------------------
// midpoint_circle_pixel_generator
// circle commands in, midpoint circle pixels out in eight-way symmetric order
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_pixel_generator (
  input  wire            clk,
  input  wire            rst,
  input  wire            cmd_valid,
  output logic           cmd_stall,
  input  mcpg_pkg::cmd_t cmd,
  output logic           pix_valid,
  input  wire            pix_stall,
  output mcpg_pkg::pix_t pix
);
  import mcpg_pkg::*;

  q_stat_t q_stat;
  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    pop_job;

  mcpg_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  mcpg_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  mcpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

endmodule

`default_nettype wire

@@ hw/rtl/mcpg_checker.sv @@
// ----------------------------------------------------------------------------
// mcpg_checker
// port-level checks for the midpoint circle pixel generator
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mcpg_checker (
  input wire            clk,
  input wire            rst,
  input wire            cmd_valid,
  input wire            cmd_stall,
  input mcpg_pkg::cmd_t cmd,
  input wire            pix_valid,
  input wire            pix_stall,
  input mcpg_pkg::pix_t pix
);
  import mcpg_pkg::*;

  logic x_in_range;
  logic y_in_range;

  always_comb begin
    x_in_range = (pix.pixel_x >= PIX_MIN) && (pix.pixel_x <= PIX_MAX);
    y_in_range = (pix.pixel_y >= PIX_MIN) && (pix.pixel_y <= PIX_MAX);
  end

  // no pixel beat right after reset
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !pix_valid)

  // a stalled pixel beat holds
  `ASSERT_CLK(a_pix_hold, clk, rst, pix_valid && pix_stall |=> pix_valid && $stable(pix))

  // pixels stay within one radius of the coordinate range
  `ASSERT_CLK(a_pix_range, clk, rst, pix_valid |-> x_in_range && y_in_range)

  // a stalled command beat holds
  `ASSERT_CLK(a_cmd_hold, clk, rst, cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))

endmodule

bind midpoint_circle_pixel_generator mcpg_checker u_mcpg_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .pix_valid (pix_valid),
  .pix_stall (pix_stall),
  .pix       (pix)
);

`default_nettype wire
